/* rtl/core/sha1_hash_stream_unit_macros.svh */
// Assertion macros used by the checker file of the hash stream unit.
`ifndef SHA1_HASH_STREAM_UNIT_MACROS_SVH
`define SHA1_HASH_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define SHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/shs_pkg.sv */
// Constants and helper functions of the SHA-1 hash stream unit.
package shs_pkg;

    localparam int SHS_WORD_W      = 32;
    localparam int SHS_BLOCK_WORDS = 16;
    localparam int SHS_CHAIN_WORDS = 5;
    localparam int SHS_ROUNDS      = 80;
    localparam int SHS_LEN_W       = 61;

    localparam logic [7:0]  SHS_PAD_BYTE = 8'h80;

    localparam logic [31:0] SHS_K0 = 32'h5A827999;
    localparam logic [31:0] SHS_K1 = 32'h6ED9EBA1;
    localparam logic [31:0] SHS_K2 = 32'h8F1BBCDC;
    localparam logic [31:0] SHS_K3 = 32'hCA62C1D6;

    // Initial chaining value, word 0 is h0.
    function automatic logic [31:0] shs_init_word(input logic [2:0] idx);
        logic [31:0] val;
        unique case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = 32'h0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/shs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module shs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sha1_hash_stream_unit.sv */
// SHA-1 digest of a byte stream. One byte is taken per request while the current
// 64-byte block fills; the 64th byte starts a compression (moving the block out of the
// block RAM into the schedule line, 80 rounds at one round per cycle, then adding into
// the chaining RAM), during which no request is taken. The request flagged
// end_of_message starts padding at one byte per cycle outside compressions (9 to 72
// bytes, with one or two compressions), then the five digest words leave h0 first, each
// read from the chaining RAM, captured and held until taken, and the unit re-initialises.
// After reset the S_INIT pass loads the initial chaining value before the first request.
module sha1_hash_stream_unit
    import shs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam int BAW = $clog2(SHS_BLOCK_WORDS);
    localparam int CAW = $clog2(SHS_CHAIN_WORDS);
    localparam int CNT_W = $clog2(SHS_BLOCK_WORDS + 1);
    localparam int RND_W = $clog2(SHS_ROUNDS);
    localparam logic [CNT_W-1:0] LOAD_LAST  = CNT_W'(SHS_BLOCK_WORDS);
    localparam logic [CNT_W-1:0] ADD_LAST   = CNT_W'(SHS_CHAIN_WORDS);
    localparam logic [CNT_W-1:0] INIT_LAST  = CNT_W'(SHS_CHAIN_WORDS - 1);
    localparam logic [RND_W-1:0] RND_LAST   = RND_W'(SHS_ROUNDS - 1);
    localparam logic [2:0]       IDX_LAST   = 3'(SHS_CHAIN_WORDS - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT_RD,
        S_OUT_CAP,
        S_OUT_HOLD
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [RND_W-1:0]   r_rnd;
    logic [5:0]         r_pos;
    logic [23:0]        r_word;
    logic [SHS_LEN_W-1:0] r_len;
    logic               r_pad_mode;
    logic               r_pad_first;
    logic               r_len_phase;
    logic               r_fin;
    logic [2:0]         r_idx;
    logic [31:0]        r_out;
    logic [31:0]        r_w [SHS_BLOCK_WORDS];
    logic [31:0]        r_a, r_b, r_c, r_d, r_e;

    logic               accept;
    logic               push_en;
    logic [7:0]         push_byte;
    logic [7:0]         pad_byte;
    logic               len_byte;
    logic [63:0]        bit_len;
    logic [31:0]        f_val, k_val, tmp_val, w_new;

    logic               blk_we;
    logic [31:0]        blk_rdata;
    logic               chn_we;
    logic [CAW-1:0]     chn_waddr;
    logic [31:0]        chn_wdata;
    logic [CAW-1:0]     chn_raddr;
    logic [31:0]        chn_rdata;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign bit_len = {r_len, 3'b000};

    // Length bytes start at position 56 once the marker byte is out.
    assign len_byte = r_len_phase || (!r_pad_first && (r_pos == 6'd56));

    always_comb begin
        if (r_pad_first) begin
            pad_byte = SHS_PAD_BYTE;
        end else if (len_byte) begin
            pad_byte = bit_len[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign push_en   = (accept && i_has_byte) || (r_state == S_PAD);
    assign push_byte = (r_state == S_PAD) ? pad_byte : i_data_byte;
    assign blk_we    = push_en && (r_pos[1:0] == 2'b11);

    always_comb begin
        if (r_rnd < RND_W'(20)) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = SHS_K0;
        end else if (r_rnd < RND_W'(40)) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = SHS_K1;
        end else if (r_rnd < RND_W'(60)) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = SHS_K2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = SHS_K3;
        end
    end

    assign tmp_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];

    always_comb begin
        logic [31:0] mix;
        mix   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_new = {mix[30:0], mix[31]};
    end

    // Chaining RAM port mux: initial fill, add-back, digest read-out and re-initialise after each word is read.
    always_comb begin
        chn_we    = 1'b0;
        chn_waddr = r_cnt[CAW-1:0];
        chn_wdata = shs_init_word(r_cnt[2:0]);
        chn_raddr = r_cnt[CAW-1:0];
        unique case (r_state)
            S_INIT: begin
                chn_we = 1'b1;
            end
            S_ADD: begin
                chn_we    = (r_cnt != '0);
                chn_waddr = CAW'(r_cnt - CNT_W'(1));
                chn_wdata = chn_rdata + r_a;
            end
            S_OUT_RD: begin
                chn_raddr = r_idx[CAW-1:0];
            end
            S_OUT_CAP: begin
                chn_we    = 1'b1;
                chn_waddr = r_idx[CAW-1:0];
                chn_wdata = shs_init_word(r_idx);
            end
            default: begin
                chn_we = 1'b0;
            end
        endcase
    end

    shs_ram #(
        .WIDTH (SHS_WORD_W),
        .DEPTH (SHS_BLOCK_WORDS)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (blk_we),
        .i_waddr (r_pos[5:2]),
        .i_wdata ({r_word, push_byte}),
        .i_raddr (r_cnt[BAW-1:0]),
        .o_rdata (blk_rdata)
    );

    shs_ram #(
        .WIDTH (SHS_WORD_W),
        .DEPTH (SHS_CHAIN_WORDS)
    ) u_chain_ram (
        .i_clk   (i_clk),
        .i_we    (chn_we),
        .i_waddr (chn_waddr),
        .i_wdata (chn_wdata),
        .i_raddr (chn_raddr),
        .o_rdata (chn_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_pad_mode  <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_phase <= 1'b0;
            r_fin       <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (push_en) begin
                r_word <= {r_word[15:0], push_byte};
                r_pos  <= r_pos + 6'd1;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == INIT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        if (i_has_byte) begin
                            r_len <= r_len + SHS_LEN_W'(1);
                        end
                        if (i_end_of_message) begin
                            r_pad_mode  <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_len_phase <= 1'b0;
                        end
                        // A full block compresses first; padding follows if flagged.
                        if (i_has_byte && (r_pos == 6'd63)) begin
                            r_fin   <= 1'b0;
                            r_state <= S_LOAD;
                        end else if (i_end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    r_cnt       <= '0;
                    if (len_byte) begin
                        r_len_phase <= 1'b1;
                    end
                    if (r_pos == 6'd63) begin
                        r_fin   <= len_byte;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt != '0) begin
                        for (int i = 0; i < SHS_BLOCK_WORDS - 1; i++) begin
                            r_w[i] <= r_w[i+1];
                        end
                        r_w[SHS_BLOCK_WORDS-1] <= blk_rdata;
                    end
                    if ((r_cnt != '0) && (r_cnt <= ADD_LAST)) begin
                        r_a <= r_b;
                        r_b <= r_c;
                        r_c <= r_d;
                        r_d <= r_e;
                        r_e <= chn_rdata;
                    end
                    if (r_cnt == LOAD_LAST) begin
                        r_rnd   <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < SHS_BLOCK_WORDS - 1; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[SHS_BLOCK_WORDS-1] <= w_new;
                    r_e   <= r_d;
                    r_d   <= r_c;
                    r_c   <= {r_b[1:0], r_b[31:2]};
                    r_b   <= r_a;
                    r_a   <= tmp_val;
                    r_rnd <= r_rnd + RND_W'(1);
                    r_cnt <= '0;
                    if (r_rnd == RND_LAST) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt != '0) begin
                        r_a <= r_b;
                        r_b <= r_c;
                        r_c <= r_d;
                        r_d <= r_e;
                    end
                    if (r_cnt == ADD_LAST) begin
                        r_idx <= '0;
                        if (r_fin) begin
                            r_state <= S_OUT_RD;
                        end else if (r_pad_mode) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_CAP;
                end
                S_OUT_CAP: begin
                    r_out   <= chn_rdata;
                    r_state <= S_OUT_HOLD;
                end
                S_OUT_HOLD: begin
                    if (i_ready) begin
                        if (r_idx == IDX_LAST) begin
                            r_len       <= '0;
                            r_pad_mode  <= 1'b0;
                            r_fin       <= 1'b0;
                            r_len_phase <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 3'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT_HOLD);
    assign o_digest_word = r_out;
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == IDX_LAST);

endmodule

/* rtl/core/shs_checker.sv */
// Port-level checks of the hash stream unit, bound to the top level.
`include "sha1_hash_stream_unit_macros.svh"

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // A digest word waiting for its request holds its value.
    `SHS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_digest_word) && $stable(o_word_index), "digest word changed while stalled")

    // Input is never taken while a digest word is shown.
    `SHS_ASSERT_NOW(a_no_overlap, o_valid, !o_ready, "input ready while digest word pending")

    // Last flag marks exactly the fifth word.
    `SHS_ASSERT_NOW(a_last_idx, o_valid, o_last_word == (o_word_index == 3'd4), "last flag and index disagree")

    // After a non-final word is taken, the next word is read out from memory first.
    `SHS_ASSERT_NEXT(a_gap, o_valid && i_ready && !o_last_word, !o_valid && !o_ready, "no read-out gap between digest words")

endmodule

bind sha1_hash_stream_unit shs_checker u_shs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
